@@ rtl/gabor_line_edge_classifier_defines.svh @@
// Assertion helpers shared by the checker
`ifndef GABOR_LINE_EDGE_CLASSIFIER_DEFINES_SVH
`define GABOR_LINE_EDGE_CLASSIFIER_DEFINES_SVH

// implication checked every clock outside reset
`define GLEC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("glec check failed");

// next-cycle implication
`define GLEC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("glec check failed");

`endif

@@ rtl/glec_pkg.sv @@
`default_nettype none
package glec_pkg;
   localparam logic [1:0] REQ_WR_MAG  = 2'd0;
   localparam logic [1:0] REQ_WR_ODD  = 2'd1;
   localparam logic [1:0] REQ_WR_EVEN = 2'd2;
   localparam logic [1:0] REQ_EVAL    = 2'd3;

   localparam logic [2:0] CSR_BORDER = 3'd0;
   localparam logic [2:0] CSR_SUM    = 3'd1;
   localparam logic [2:0] CSR_PEAK   = 3'd2;
   localparam logic [2:0] CSR_NOISE  = 3'd3;
   localparam logic [2:0] CSR_STEP   = 3'd4;
   localparam logic [2:0] CSR_WIDTH  = 3'd5;
   localparam logic [2:0] CSR_HEIGHT = 3'd6;

   localparam logic [2:0] FT_NONE     = 3'd0;
   localparam logic [2:0] FT_POS_LINE = 3'd1;
   localparam logic [2:0] FT_NEG_LINE = 3'd2;
   localparam logic [2:0] FT_POS_EDGE = 3'd3;
   localparam logic [2:0] FT_NEG_EDGE = 3'd4;

   // memory selector used by controller and datapath
   localparam logic [1:0] MEM_MAG  = 2'd0;
   localparam logic [1:0] MEM_ODD  = 2'd1;
   localparam logic [1:0] MEM_EVEN = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_CLEAR  = 4'd1;
   localparam logic [3:0] OP_MAG    = 4'd2;
   localparam logic [3:0] OP_O0     = 4'd3;
   localparam logic [3:0] OP_OP     = 4'd4;
   localparam logic [3:0] OP_OM     = 4'd5;
   localparam logic [3:0] OP_E0     = 4'd6;
   localparam logic [3:0] OP_EP     = 4'd7;
   localparam logic [3:0] OP_EM     = 4'd8;
   localparam logic [3:0] OP_CP     = 4'd9;
   localparam logic [3:0] OP_CM     = 4'd10;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  border_margin;
      logic [26:0] sum_threshold;
      logic [22:0] peak_threshold;
      logic [22:0] noise_band;
      logic [3:0]  peak_step;
      logic [6:0]  active_width;
      logic [6:0]  active_height;
   } csr_type;
endpackage
`default_nettype wire

@@ rtl/glec_if.sv @@
`default_nettype none
interface glec_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [2:0]  orientation;
   logic [5:0]  row;
   logic [5:0]  col;
   logic signed [23:0] value;
   modport source (output valid, req_type, orientation, row, col, value, input ready);
   modport sink (input valid, req_type, orientation, row, col, value, output ready);
endinterface

interface glec_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  out_row;
   logic [5:0]  out_col;
   logic        found;
   logic [2:0]  feature_type;
   logic [2:0]  best_orientation;
   logic [22:0] response;
   modport source (output valid, out_row, out_col, found, feature_type, best_orientation,
      response, input ready);
   modport sink (input valid, out_row, out_col, found, feature_type, best_orientation,
      response, output ready);
endinterface

interface glec_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [26:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/gabor_line_edge_classifier.sv @@
// channel   dir   payload
// req       in    req_type, orientation, row, col, value
// rsp       out   out_row, out_col, found, feature_type, best_orientation, response
// csr       in    index, data
// An evaluate reads the maps through the single read port of each map RAM,
// one word per cycle. The result sits in an output register; the next item is
// taken once it is gone. Synchronous active-high reset; the maps are not
// cleared.
`default_nettype none
module gabor_line_edge_classifier #(
   parameter int ORIENTATIONS = 8,
   parameter int IMG_WIDTH    = 64,
   parameter int IMG_HEIGHT   = 64,
   parameter int VALUE_BITS   = 24
) (
   input wire logic   clock,
   input wire logic   reset,
   glec_req_if.sink   req,
   glec_rsp_if.source rsp,
   glec_csr_if.sink   csr
);
   import glec_pkg::*;

   localparam int OW = $clog2(ORIENTATIONS);
   localparam int AW = OW + $clog2(IMG_HEIGHT) + $clog2(IMG_WIDTH);

   csr_type csr_ff;
   cmd_type cmd;
   logic wr_en;
   logic [1:0] wr_sel, rd_sel;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [OW-1:0] rd_ori, best_ori;
   logic thr_ok, found;
   logic [2:0] ftype;
   logic [22:0] response;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.border_margin  <= 6'd4;
         csr_ff.sum_threshold  <= 27'd51200;
         csr_ff.peak_threshold <= 23'd12800;
         csr_ff.noise_band     <= 23'd256;
         csr_ff.peak_step      <= 4'd1;
         csr_ff.active_width   <= 7'd64;
         csr_ff.active_height  <= 7'd64;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_BORDER: csr_ff.border_margin  <= csr.data[5:0];
            CSR_SUM:    csr_ff.sum_threshold  <= csr.data;
            CSR_PEAK:   csr_ff.peak_threshold <= csr.data[22:0];
            CSR_NOISE:  csr_ff.noise_band     <= csr.data[22:0];
            CSR_STEP:   csr_ff.peak_step      <= csr.data[3:0];
            CSR_WIDTH:  csr_ff.active_width   <= csr.data[6:0];
            CSR_HEIGHT: csr_ff.active_height  <= csr.data[6:0];
            default: ;
         endcase
      end
   end

   glec_ctrl #(.ORIENTATIONS(ORIENTATIONS), .IMG_WIDTH(IMG_WIDTH),
      .IMG_HEIGHT(IMG_HEIGHT), .VALUE_BITS(VALUE_BITS)) u_ctrl (
      .clock, .reset, .req, .rsp, .csr(csr_ff), .wr_en, .wr_sel, .wr_addr,
      .wr_data, .rd_sel, .rd_addr, .rd_ori, .cmd, .best_ori, .thr_ok, .found,
      .ftype, .response);

   glec_datapath #(.ORIENTATIONS(ORIENTATIONS), .IMG_WIDTH(IMG_WIDTH),
      .IMG_HEIGHT(IMG_HEIGHT), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock, .wr_en, .wr_sel, .wr_addr, .wr_data, .rd_sel, .rd_addr, .rd_ori,
      .cmd, .csr(csr_ff), .best_ori, .thr_ok, .found, .ftype, .response);
endmodule
`default_nettype wire

@@ rtl/glec_ram.sv @@
`default_nettype none
module glec_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/glec_datapath.sv @@
`default_nettype none
module glec_datapath #(
   parameter int ORIENTATIONS = 8,
   parameter int IMG_WIDTH    = 64,
   parameter int IMG_HEIGHT   = 64,
   parameter int VALUE_BITS   = 24,
   parameter int OW = $clog2(ORIENTATIONS),
   parameter int RW = $clog2(IMG_HEIGHT),
   parameter int CW = $clog2(IMG_WIDTH),
   parameter int AW = OW + RW + CW
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [1:0]             wr_sel,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [VALUE_BITS-1:0]  wr_data,
   input  wire logic [1:0]             rd_sel,
   input  wire logic [AW-1:0]          rd_addr,
   input  wire logic [OW-1:0]          rd_ori,
   input  wire glec_pkg::cmd_type      cmd,
   input  wire glec_pkg::csr_type      csr,
   output logic [OW-1:0]               best_ori,
   output logic                        thr_ok,
   output logic                        found,
   output logic [2:0]                  ftype,
   output logic [22:0]                 response
);
   import glec_pkg::*;

   localparam int SW = VALUE_BITS + OW + 1;

   logic [VALUE_BITS-1:0] mag_q, odd_q, even_q, rd_q;
   logic signed [VALUE_BITS-1:0] rv;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [VALUE_BITS-1:0] best_ff, best_in;
   logic [OW-1:0] bori_ff, bori_in;
   logic signed [VALUE_BITS-1:0] o0_ff, op_ff, om_ff, e0_ff, ep_ff, em_ff;
   logic signed [VALUE_BITS-1:0] cp_ff, cm_ff;
   logic signed [VALUE_BITS:0] nb;
   logic romax, romin, remax, remin, rozc, rezc, noise;

   glec_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << AW)) u_mag (
      .clock, .wr_en(wr_en && wr_sel == MEM_MAG), .wr_addr, .wr_data,
      .rd_addr, .rd_data(mag_q));
   glec_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << AW)) u_odd (
      .clock, .wr_en(wr_en && wr_sel == MEM_ODD), .wr_addr, .wr_data,
      .rd_addr, .rd_data(odd_q));
   glec_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << AW)) u_even (
      .clock, .wr_en(wr_en && wr_sel == MEM_EVEN), .wr_addr, .wr_data,
      .rd_addr, .rd_data(even_q));

   logic [1:0] rsel_ff;
   logic [OW-1:0] rori_ff;
   always_ff @(posedge clock) begin
      rsel_ff <= rd_sel;
      rori_ff <= rd_ori;
   end

   always_comb begin
      case (rsel_ff)
         MEM_ODD:  rd_q = odd_q;
         MEM_EVEN: rd_q = even_q;
         default:  rd_q = mag_q;
      endcase
   end
   assign rv = $signed(rd_q);

   always_comb begin
      sum_in  = sum_ff;
      best_in = best_ff;
      bori_in = bori_ff;
      case (cmd.op)
         OP_CLEAR: begin
            sum_in  = '0;
            best_in = '0;
            bori_in = '0;
         end
         OP_MAG: begin
            sum_in = sum_ff + SW'(rv);
            if (rv > best_ff) begin
               best_in = rv;
               bori_in = rori_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      best_ff <= best_in;
      bori_ff <= bori_in;
      if (cmd.op == OP_O0) o0_ff <= rv;
      if (cmd.op == OP_OP) op_ff <= rv;
      if (cmd.op == OP_OM) om_ff <= rv;
      if (cmd.op == OP_E0) e0_ff <= rv;
      if (cmd.op == OP_EP) ep_ff <= rv;
      if (cmd.op == OP_EM) em_ff <= rv;
      if (cmd.op == OP_CP) cp_ff <= rv;
      if (cmd.op == OP_CM) cm_ff <= rv;
   end

   assign best_ori = bori_ff;
   assign response = 23'(best_ff);
   assign thr_ok = (sum_ff > $signed({1'b0, SW'(csr.sum_threshold)}))
      && (best_ff >= $signed({1'b0, VALUE_BITS'(csr.peak_threshold)}));

   assign nb    = $signed({1'b0, VALUE_BITS'(csr.noise_band)});
   assign romax = o0_ff > op_ff && o0_ff > om_ff;
   assign romin = o0_ff < op_ff && o0_ff < om_ff;
   assign remax = e0_ff > ep_ff && e0_ff > em_ff;
   assign remin = e0_ff < ep_ff && e0_ff < em_ff;
   assign rozc  = (op_ff < 0 && om_ff > 0) || (op_ff > 0 && om_ff < 0);
   assign rezc  = (ep_ff < 0 && em_ff > 0) || (ep_ff > 0 && em_ff < 0);
   assign noise = (VALUE_BITS+1)'(e0_ff) < nb && (VALUE_BITS+1)'(o0_ff) < nb
      && (VALUE_BITS+1)'(e0_ff) > -nb && (VALUE_BITS+1)'(o0_ff) > -nb;

   always_comb begin
      found = (romax || romin || remax || remin) && (rozc || rezc)
         && best_ff > cp_ff && best_ff > cm_ff && !noise;
      ftype = FT_NONE;
      if (rezc && romin)      ftype = FT_NEG_EDGE;
      else if (rezc && romax) ftype = FT_POS_EDGE;
      else if (rozc && remin) ftype = FT_NEG_LINE;
      else if (rozc && remax) ftype = FT_POS_LINE;
   end
endmodule
`default_nettype wire

@@ rtl/glec_ctrl.sv @@
`default_nettype none
module glec_ctrl #(
   parameter int ORIENTATIONS = 8,
   parameter int IMG_WIDTH    = 64,
   parameter int IMG_HEIGHT   = 64,
   parameter int VALUE_BITS   = 24,
   parameter int OW = $clog2(ORIENTATIONS),
   parameter int RW = $clog2(IMG_HEIGHT),
   parameter int CW = $clog2(IMG_WIDTH),
   parameter int AW = OW + RW + CW
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   glec_req_if.sink                   req,
   glec_rsp_if.source                 rsp,
   input  wire glec_pkg::csr_type     csr,
   output logic                       wr_en,
   output logic [1:0]                 wr_sel,
   output logic [AW-1:0]              wr_addr,
   output logic [VALUE_BITS-1:0]      wr_data,
   output logic [1:0]                 rd_sel,
   output logic [AW-1:0]              rd_addr,
   output logic [OW-1:0]              rd_ori,
   output glec_pkg::cmd_type          cmd,
   input  wire logic [OW-1:0]         best_ori,
   input  wire logic                  thr_ok,
   input  wire logic                  found,
   input  wire logic [2:0]            ftype,
   input  wire logic [22:0]           response
);
   import glec_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAG  = 3'd1;
   localparam logic [2:0] ST_GEO  = 3'd2;
   localparam logic [2:0] ST_NBR  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam int SEQ = 10;

   logic [2:0] state_ff, state_in;
   logic [OW:0] cnt_ff, cnt_in;
   logic [3:0] seq_ff, seq_in;
   logic [5:0] row_ff, col_ff;
   logic signed [11:0] h, w, m, rr, cc;
   logic signed [1:0] dx, dy;
   logic signed [11:0] s, nr, nc;
   logic inner, geo_ok_ff, geo_ok_in, pass_ff, pass_in;
   logic ov_ff, ov_in;
   logic [5:0] orow_ff, ocol_ff;
   logic fnd_ff, fnd_in;
   logic [2:0] ft_ff, ft_in;
   logic [OW-1:0] bo_ff, bo_in;
   logic [22:0] rs_ff, rs_in;
   logic signed [11:0] kb, n3;

   assign h  = (csr.active_height > 7'(IMG_HEIGHT)) ? 12'(IMG_HEIGHT)
      : 12'(csr.active_height);
   assign w  = (csr.active_width > 7'(IMG_WIDTH)) ? 12'(IMG_WIDTH)
      : 12'(csr.active_width);
   assign m  = 12'(csr.border_margin);
   assign rr = 12'(row_ff);
   assign cc = 12'(col_ff);
   assign s  = 12'(csr.peak_step);
   assign inner = rr >= m && rr < h - m && cc >= m && cc < w - m;
   assign kb = 12'(best_ori);
   assign n3 = 12'(ORIENTATIONS);
   assign dx = (3 * kb <= n3) ? 2'sd1 : ((3 * kb >= 2 * n3) ? -2'sd1 : 2'sd0);
   assign dy = (6 * kb >= n3 && 6 * kb <= 5 * n3) ? 2'sd1 : 2'sd0;

   // neighbor for each sequence step: 0 center, +/-1 unit, +/-s peak
   always_comb begin
      case (seq_ff)
         4'd1, 4'd4: begin nr = rr + 12'(dy); nc = cc + 12'(dx); end
         4'd2, 4'd5: begin nr = rr - 12'(dy); nc = cc - 12'(dx); end
         4'd6: begin nr = rr + 12'(dy) * s; nc = cc + 12'(dx) * s; end
         4'd7: begin nr = rr - 12'(dy) * s; nc = cc - 12'(dx) * s; end
         default: begin nr = rr; nc = cc; end
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.out_row = orow_ff;
   assign rsp.out_col = ocol_ff;
   assign rsp.found = fnd_ff;
   assign rsp.feature_type = ft_ff;
   assign rsp.best_orientation = 3'(bo_ff);
   assign rsp.response = rs_ff;

   assign wr_en   = req.valid && req.ready && req.req_type != REQ_EVAL
      && 32'(req.orientation) < ORIENTATIONS && 32'(req.row) < IMG_HEIGHT
      && 32'(req.col) < IMG_WIDTH;
   assign wr_sel  = req.req_type;
   assign wr_addr = {OW'(req.orientation), RW'(req.row), CW'(req.col)};
   assign wr_data = VALUE_BITS'(req.value);

   always_comb begin
      rd_sel  = MEM_MAG;
      rd_ori  = OW'(cnt_ff);
      rd_addr = {OW'(cnt_ff), RW'(row_ff), CW'(col_ff)};
      if (state_ff == ST_NBR) begin
         rd_ori  = best_ori;
         rd_addr = {best_ori, RW'(nr[5:0]), CW'(nc[5:0])};
         case (seq_ff)
            4'd0, 4'd1, 4'd2: rd_sel = MEM_ODD;
            4'd3, 4'd4, 4'd5: rd_sel = MEM_EVEN;
            default: rd_sel = MEM_MAG;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      seq_in = seq_ff;
      geo_ok_in = geo_ok_ff;
      pass_in = pass_ff;
      ov_in = ov_ff;
      fnd_in = fnd_ff; ft_in = ft_ff; bo_in = bo_ff; rs_in = rs_ff;
      cmd.op = OP_NONE;
      if (rsp.valid && rsp.ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready && req.req_type == REQ_EVAL) begin
               state_in = ST_MAG;
               cnt_in = '0;
               cmd.op = OP_CLEAR;
            end
         end
         ST_MAG: begin
            // read address cnt issued now; its data is accumulated in the next cycle
            if (cnt_ff != '0) cmd.op = OP_MAG;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == ORIENTATIONS) begin
               state_in = ST_GEO;
               cmd.op = OP_MAG;
            end
         end
         ST_GEO: begin
            seq_in = 4'd0;
            geo_ok_in = 1'b1;
            pass_in = inner && thr_ok;
            state_in = ST_NBR;
         end
         ST_NBR: begin
            if (seq_ff < 4'd8 && !(nr >= 0 && nr < h && nc >= 0 && nc < w))
               geo_ok_in = 1'b0;
            case (seq_ff)
               4'd1: cmd.op = OP_O0;
               4'd2: cmd.op = OP_OP;
               4'd3: cmd.op = OP_OM;
               4'd4: cmd.op = OP_E0;
               4'd5: cmd.op = OP_EP;
               4'd6: cmd.op = OP_EM;
               4'd7: cmd.op = OP_CP;
               4'd8: cmd.op = OP_CM;
               default: cmd.op = OP_NONE;
            endcase
            seq_in = seq_ff + 1'b1;
            if (seq_ff == 4'(SEQ - 2)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               fnd_in = 1'b0; ft_in = FT_NONE; bo_in = '0; rs_in = '0;
               if (inner) begin
                  bo_in = best_ori;
                  rs_in = response;
                  if (pass_ff && geo_ok_ff && found) begin
                     fnd_in = 1'b1;
                     ft_in = ftype;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         cnt_ff <= '0;
         seq_ff <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         cnt_ff <= cnt_in;
         seq_ff <= seq_in;
      end
      geo_ok_ff <= geo_ok_in;
      pass_ff <= pass_in;
      fnd_ff <= fnd_in; ft_ff <= ft_in; bo_ff <= bo_in; rs_ff <= rs_in;
      orow_ff <= (state_ff == ST_DONE && !ov_ff) ? row_ff : orow_ff;
      ocol_ff <= (state_ff == ST_DONE && !ov_ff) ? col_ff : ocol_ff;
      if (req.valid && req.ready) begin
         row_ff <= req.row;
         col_ff <= req.col;
      end
   end
endmodule
`default_nettype wire

@@ rtl/glec_checker.sv @@
`default_nettype none
`include "gabor_line_edge_classifier_defines.svh"
module glec_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_type,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       found,
   input wire logic [2:0] feature_type
);
   import glec_pkg::*;
   // no type reported without a feature
   `GLEC_ASSERT_IMP(a_type_needs_found, clock, reset, rsp_valid && !found, feature_type == FT_NONE)
   // result held while stalled
   `GLEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // an evaluate never yields a result in the next cycle
   `GLEC_ASSERT_NEXT(a_eval_latency, clock, reset, req_valid && req_ready && req_type == REQ_EVAL, !rsp_valid)
endmodule

bind gabor_line_edge_classifier glec_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .found(rsp.found),
   .feature_type(rsp.feature_type));
`default_nettype wire
